>>> design/rre_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types, constants and microcode codes of the rate ratio estimator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int RATIO_FRAC_BITS_DEF = 24;
  localparam int SPEED_FRAC_BITS_DEF = 16;

  localparam int FRAMES_W = 16;
  localparam int SPEED_W  = 17;
  localparam int RATIO_W  = 32;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int PROD_W   = SPEED_W + RATIO_W;
  localparam int NUM_W    = FRAMES_W + TIME_W;
  localparam int DIV_BITS = RATIO_W;
  localparam int CNT_W    = $clog2(DIV_BITS);
  localparam int ADDR_W   = 4;
  localparam int PC_W     = 4;

  localparam logic [KIND_W-1:0] KIND_IN_BLOCK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OUT_BLOCK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK      = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART   = 2'd3;

  localparam logic [1:0] REG_IN_FRAMES     = 2'd0;
  localparam logic [1:0] REG_OUT_FRAMES    = 2'd1;
  localparam logic [1:0] REG_SPEED         = 2'd2;
  localparam logic [1:0] REG_RESTART_RATIO = 2'd3;

  localparam logic [FRAMES_W-1:0] FRAMES_RST = 16'd256;
  localparam logic [SPEED_W-1:0]  SPEED_RST  = 17'd655;

  localparam logic [PC_W-1:0] PC_EVENT    = 4'd0;
  localparam logic [PC_W-1:0] PC_MUL_NUM  = 4'd1;
  localparam logic [PC_W-1:0] PC_MUL_DEN  = 4'd2;
  localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd3;
  localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd4;
  localparam logic [PC_W-1:0] PC_DIFF     = 4'd5;
  localparam logic [PC_W-1:0] PC_MUL_STEP = 4'd6;
  localparam logic [PC_W-1:0] PC_APPLY    = 4'd7;
  localparam logic [PC_W-1:0] PC_FIN      = 4'd8;

  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_EVENT    = 4'd1,
    OP_MUL_NUM  = 4'd2,
    OP_MUL_DEN  = 4'd3,
    OP_DIV_INIT = 4'd4,
    OP_DIV_STEP = 4'd5,
    OP_DIFF     = 4'd6,
    OP_MUL_STEP = 4'd7,
    OP_APPLY    = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    COND_NEXT      = 2'd0,
    COND_NO_UPDATE = 2'd1,
    COND_SAT       = 2'd2,
    COND_DIV_MORE  = 2'd3
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            fin;
  } uword_t;

  typedef struct packed {
    logic no_update;
    logic sat;
    logic div_more;
  } dp_status_t;

  typedef struct packed {
    op_t  op;
    logic done;
    logic busy;
  } seq_ctrl_t;

  typedef struct packed {
    logic [FRAMES_W-1:0] in_frames;
    logic [FRAMES_W-1:0] out_frames;
    logic [SPEED_W-1:0]  speed;
    logic [RATIO_W-1:0]  restart_ratio;
  } cfg_t;

endpackage
`default_nettype wire

>>> design/rre_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rre_seq
// Microcode sequencer: program table, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module rre_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                out_free,
  input  wire rre_pkg::dp_status_t status,
  output rre_pkg::seq_ctrl_t       ctrl
);

  function automatic rre_pkg::uword_t rom(input logic [rre_pkg::PC_W-1:0] pc);
    rre_pkg::uword_t w;
    w = '{op: rre_pkg::OP_NOP, cond: rre_pkg::COND_NEXT,
          target: rre_pkg::PC_FIN, fin: 1'b1};
    case (pc)
      rre_pkg::PC_EVENT: begin
        w = '{rre_pkg::OP_EVENT, rre_pkg::COND_NO_UPDATE, rre_pkg::PC_FIN, 1'b0};
      end
      rre_pkg::PC_MUL_NUM: begin
        w = '{rre_pkg::OP_MUL_NUM, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b0};
      end
      rre_pkg::PC_MUL_DEN: begin
        w = '{rre_pkg::OP_MUL_DEN, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b0};
      end
      rre_pkg::PC_DIV_INIT: begin
        w = '{rre_pkg::OP_DIV_INIT, rre_pkg::COND_SAT, rre_pkg::PC_DIFF, 1'b0};
      end
      rre_pkg::PC_DIV_STEP: begin
        w = '{rre_pkg::OP_DIV_STEP, rre_pkg::COND_DIV_MORE, rre_pkg::PC_DIV_STEP, 1'b0};
      end
      rre_pkg::PC_DIFF: begin
        w = '{rre_pkg::OP_DIFF, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b0};
      end
      rre_pkg::PC_MUL_STEP: begin
        w = '{rre_pkg::OP_MUL_STEP, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b0};
      end
      rre_pkg::PC_APPLY: begin
        w = '{rre_pkg::OP_APPLY, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b0};
      end
      default: begin
        w = '{rre_pkg::OP_NOP, rre_pkg::COND_NEXT, rre_pkg::PC_FIN, 1'b1};
      end
    endcase
    return w;
  endfunction

  logic [rre_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                     busy_r, busy_nxt;
  rre_pkg::uword_t          word;
  logic                     jump;
  logic                     done;

  assign word = rom(pc_r);

  always_comb begin
    unique case (word.cond)
      rre_pkg::COND_NEXT:      jump = 1'b0;
      rre_pkg::COND_NO_UPDATE: jump = status.no_update;
      rre_pkg::COND_SAT:       jump = status.sat;
      rre_pkg::COND_DIV_MORE:  jump = status.div_more;
      default:                 jump = 1'b0;
    endcase
  end

  assign done = busy_r && word.fin && out_free;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        pc_nxt   = rre_pkg::PC_EVENT;
      end
    end else if (word.fin) begin
      if (out_free) begin
        busy_nxt = 1'b0;
      end
    end else if (jump) begin
      pc_nxt = word.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= rre_pkg::PC_EVENT;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign ctrl.op   = busy_r ? word.op : rre_pkg::OP_NOP;
  assign ctrl.done = done;
  assign ctrl.busy = busy_r;

endmodule
`default_nettype wire

>>> design/rre_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rre_datapath
// Timing state, shared multiplier, bit-serial divider and ratio blend.
// ----------------------------------------------------------------------------
module rre_datapath #(
  parameter int RATIO_FRAC_BITS = rre_pkg::RATIO_FRAC_BITS_DEF,
  parameter int SPEED_FRAC_BITS = rre_pkg::SPEED_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire logic [rre_pkg::KIND_W-1:0]  kind,
  input  wire logic [rre_pkg::TIME_W-1:0]  time_us,
  input  wire rre_pkg::cfg_t               cfg,
  input  wire rre_pkg::op_t                op,
  output rre_pkg::dp_status_t              status,
  output logic [rre_pkg::RATIO_W-1:0]      ratio,
  output logic                             rates_known
);

  localparam int SH   = rre_pkg::RATIO_W - RATIO_FRAC_BITS;
  localparam int CMPW = rre_pkg::NUM_W + SH;
  localparam int AW   = (SPEED_FRAC_BITS + 1 > rre_pkg::SPEED_W) ?
                        SPEED_FRAC_BITS + 1 : rre_pkg::SPEED_W;
  localparam logic [AW-1:0] SPEED_ONE = AW'(1) << SPEED_FRAC_BITS;
  localparam logic [rre_pkg::RATIO_W-1:0] RATIO_ONE =
    rre_pkg::RATIO_W'(1) << RATIO_FRAC_BITS;

  logic [rre_pkg::KIND_W-1:0]  kind_r;
  logic [rre_pkg::TIME_W-1:0]  time_r;
  logic [rre_pkg::TIME_W-1:0]  in_last_r, out_last_r;
  logic                        in_tv_r, out_tv_r;
  logic [rre_pkg::TIME_W-1:0]  in_period_r, out_period_r;
  logic [rre_pkg::RATIO_W-1:0] ratio_r;

  logic [rre_pkg::NUM_W-1:0]   num_r, den_r, rem_r;
  logic [rre_pkg::RATIO_W-1:0] low_r, q_r, diff_r;
  logic [rre_pkg::CNT_W-1:0]   cnt_r;
  logic                        up_r;
  logic [rre_pkg::PROD_W-1:0]  step_r;

  logic [rre_pkg::SPEED_W-1:0] mul_a, a_sat;
  logic [rre_pkg::RATIO_W-1:0] mul_b;
  logic [rre_pkg::PROD_W-1:0]  prod;
  logic [rre_pkg::NUM_W:0]     trial;
  logic                        trial_ge;
  logic [rre_pkg::TIME_W-1:0]  in_d, out_d;
  logic [rre_pkg::RATIO_W-1:0] step_val;
  logic                        known;

  assign a_sat = (AW'(cfg.speed) > SPEED_ONE) ? SPEED_ONE[rre_pkg::SPEED_W-1:0] : cfg.speed;

  always_comb begin
    unique case (op)
      rre_pkg::OP_MUL_NUM: begin
        mul_a = {1'b0, cfg.out_frames};
        mul_b = in_period_r;
      end
      rre_pkg::OP_MUL_DEN: begin
        mul_a = {1'b0, cfg.in_frames};
        mul_b = out_period_r;
      end
      default: begin
        mul_a = a_sat;
        mul_b = diff_r;
      end
    endcase
  end

  assign prod     = rre_pkg::PROD_W'(mul_a) * rre_pkg::PROD_W'(mul_b);
  assign trial    = {rem_r, low_r[rre_pkg::RATIO_W-1]};
  assign trial_ge = trial >= {1'b0, den_r};
  assign in_d     = time_r - in_last_r;
  assign out_d    = time_r - out_last_r;
  assign step_val = rre_pkg::RATIO_W'(step_r >> SPEED_FRAC_BITS);
  assign known    = (in_period_r != '0) && (out_period_r != '0);

  assign status.no_update = (kind_r != rre_pkg::KIND_TICK) || !known;
  assign status.sat       = (den_r == '0) ||
                            (CMPW'(num_r) >= (CMPW'(den_r) << SH));
  assign status.div_more  = cnt_r != '0;

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind;
      time_r <= time_us;
    end
    unique case (op)
      rre_pkg::OP_MUL_NUM:  num_r  <= prod[rre_pkg::NUM_W-1:0];
      rre_pkg::OP_MUL_DEN:  den_r  <= prod[rre_pkg::NUM_W-1:0];
      rre_pkg::OP_DIV_INIT: begin
        rem_r <= num_r >> SH;
        low_r <= num_r[rre_pkg::RATIO_W-1:0] << RATIO_FRAC_BITS;
        cnt_r <= rre_pkg::CNT_W'(rre_pkg::DIV_BITS - 1);
        q_r   <= '1;
      end
      rre_pkg::OP_DIV_STEP: begin
        rem_r <= trial_ge ? rre_pkg::NUM_W'(trial - {1'b0, den_r})
                          : trial[rre_pkg::NUM_W-1:0];
        low_r <= low_r << 1;
        q_r   <= {q_r[rre_pkg::RATIO_W-2:0], trial_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      rre_pkg::OP_DIFF: begin
        up_r   <= q_r >= ratio_r;
        diff_r <= (q_r >= ratio_r) ? q_r - ratio_r : ratio_r - q_r;
      end
      rre_pkg::OP_MUL_STEP: step_r <= prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_last_r    <= '0;
      out_last_r   <= '0;
      in_tv_r      <= 1'b0;
      out_tv_r     <= 1'b0;
      in_period_r  <= '0;
      out_period_r <= '0;
      ratio_r      <= RATIO_ONE;
    end else begin
      unique case (op)
        rre_pkg::OP_EVENT: begin
          unique case (kind_r)
            rre_pkg::KIND_IN_BLOCK: begin
              if (in_tv_r && in_d != '0) begin
                in_period_r <= in_d;
              end
              in_last_r <= time_r;
              in_tv_r   <= 1'b1;
            end
            rre_pkg::KIND_OUT_BLOCK: begin
              if (out_tv_r && out_d != '0) begin
                out_period_r <= out_d;
              end
              out_last_r <= time_r;
              out_tv_r   <= 1'b1;
            end
            rre_pkg::KIND_RESTART: begin
              in_last_r    <= '0;
              out_last_r   <= '0;
              in_tv_r      <= 1'b0;
              out_tv_r     <= 1'b0;
              in_period_r  <= '0;
              out_period_r <= '0;
              ratio_r      <= cfg.restart_ratio;
            end
            default: ;
          endcase
        end
        rre_pkg::OP_APPLY: begin
          ratio_r <= up_r ? ratio_r + step_val : ratio_r - step_val;
        end
        default: ;
      endcase
    end
  end

  assign ratio       = ratio_r;
  assign rates_known = known;

endmodule
`default_nettype wire

>>> design/rate_ratio_estimator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rate_ratio_estimator
// Tracks the output/input sample rate ratio of an asynchronous rate
// converter from block arrival timestamps, blended with an adaption speed.
//
//   Channel  Direction  Handshake            Payload
//   in_      request    in_valid, in_stall   in_kind, in_time_us
//   out_     result     out_valid, out_stall out_ratio, out_rates_known
//   cfg      APB r/w    psel, penable, pready paddr, pwdata, prdata
//
// A block event, restart or idle tick runs two microcode steps; an update
// tick runs 40 steps, 32 of them in the one-bit-per-step divider, and
// 8 steps when the target saturates and the divider is skipped.
// A new request is taken the cycle after the previous result is registered.
// A stalled result holds the sequencer in its final step.
// Reset is synchronous and active low and restores the register defaults.
// ----------------------------------------------------------------------------
module rate_ratio_estimator #(
  parameter int RATIO_FRAC_BITS = rre_pkg::RATIO_FRAC_BITS_DEF,
  parameter int SPEED_FRAC_BITS = rre_pkg::SPEED_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rre_pkg::KIND_W-1:0]  in_kind,
  input  wire logic [rre_pkg::TIME_W-1:0]  in_time_us,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [rre_pkg::RATIO_W-1:0]      out_ratio,
  output logic                             out_rates_known,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rre_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam logic [rre_pkg::RATIO_W-1:0] RATIO_ONE =
    rre_pkg::RATIO_W'(1) << RATIO_FRAC_BITS;

  rre_pkg::cfg_t       cfg_r;
  rre_pkg::seq_ctrl_t  ctrl;
  rre_pkg::dp_status_t status;
  logic                out_valid_r;
  logic [rre_pkg::RATIO_W-1:0] out_ratio_r;
  logic                out_known_r;
  logic [rre_pkg::RATIO_W-1:0] ratio;
  logic                rates_known;
  logic                accept;
  logic                out_free;
  logic                wr_en;
  logic [1:0]          reg_idx;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && pready;
  assign reg_idx  = paddr[3:2];
  assign in_stall = ctrl.busy;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_frames     <= rre_pkg::FRAMES_RST;
      cfg_r.out_frames    <= rre_pkg::FRAMES_RST;
      cfg_r.speed         <= rre_pkg::SPEED_RST;
      cfg_r.restart_ratio <= RATIO_ONE;
    end else if (wr_en) begin
      unique case (reg_idx)
        rre_pkg::REG_IN_FRAMES:  cfg_r.in_frames  <= pwdata[rre_pkg::FRAMES_W-1:0];
        rre_pkg::REG_OUT_FRAMES: cfg_r.out_frames <= pwdata[rre_pkg::FRAMES_W-1:0];
        rre_pkg::REG_SPEED:      cfg_r.speed      <= pwdata[rre_pkg::SPEED_W-1:0];
        rre_pkg::REG_RESTART_RATIO: cfg_r.restart_ratio <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rre_pkg::REG_IN_FRAMES:     prdata = 32'(cfg_r.in_frames);
      rre_pkg::REG_OUT_FRAMES:    prdata = 32'(cfg_r.out_frames);
      rre_pkg::REG_SPEED:         prdata = 32'(cfg_r.speed);
      rre_pkg::REG_RESTART_RATIO: prdata = cfg_r.restart_ratio;
      default:                    prdata = '0;
    endcase
  end

  rre_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl)
  );

  rre_datapath #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS),
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (accept),
    .kind        (in_kind),
    .time_us     (in_time_us),
    .cfg         (cfg_r),
    .op          (ctrl.op),
    .status      (status),
    .ratio       (ratio),
    .rates_known (rates_known)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      out_ratio_r <= ratio;
      out_known_r <= rates_known;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ratio       = out_ratio_r;
  assign out_rates_known = out_known_r;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ctrl.busy)
    else $error("Sequencer did not start on an accepted request.");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !ctrl.busy) |=> !out_valid_r)
    else $error("Result appeared without a request in progress.");

  a_done_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.done |-> out_free)
    else $error("Result written over an undelivered result.");
`endif

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rate ratio estimator. Block events, update
// ticks and restarts are driven in random bursts against a receiver that
// stalls on its own pattern. A software copy of the estimator computes the
// expected ratio and rates-known flag for every accepted request, and each
// result is compared in order. Register settings are changed between phases
// while the block is idle, covering zero frame counts, speed saturation and
// extreme initial ratios.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RFRAC = rre_pkg::RATIO_FRAC_BITS_DEF;
  localparam int SFRAC = rre_pkg::SPEED_FRAC_BITS_DEF;

  typedef struct packed {
    logic [rre_pkg::KIND_W-1:0] kind;
    logic [rre_pkg::TIME_W-1:0] time_us;
  } rate_request_t;

  typedef struct packed {
    logic [rre_pkg::RATIO_W-1:0] ratio;
    logic                        rates_known;
  } ratio_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         in_valid = 1'b0;
  wire                          in_stall;
  logic [rre_pkg::KIND_W-1:0]   in_kind = '0;
  logic [rre_pkg::TIME_W-1:0]   in_time_us = '0;
  wire                          out_valid;
  logic                         out_stall = 1'b0;
  wire [rre_pkg::RATIO_W-1:0]   out_ratio;
  wire                          out_rates_known;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [rre_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                  pwdata = '0;
  wire [31:0]                   prdata;
  wire                          pready;

  rate_ratio_estimator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_time_us     (in_time_us),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ratio      (out_ratio),
    .out_rates_known(out_rates_known),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rate_request_t rate_requests[$];
  ratio_result_t ratio_expected[$];
  int issued_cnt = 0;
  int checked_cnt = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  // Estimator state as seen by the bench.
  rre_pkg::cfg_t               cfg_now;
  logic [rre_pkg::TIME_W-1:0]  in_last;
  logic                        in_seen;
  logic [rre_pkg::TIME_W-1:0]  out_last;
  logic                        out_seen;
  logic [rre_pkg::TIME_W-1:0]  in_per;
  logic [rre_pkg::TIME_W-1:0]  out_per;
  logic [rre_pkg::RATIO_W-1:0] ratio_est;

  task automatic clear_timing();
    in_last = '0;
    in_seen = 1'b0;
    out_last = '0;
    out_seen = 1'b0;
    in_per = '0;
    out_per = '0;
  endtask

  function automatic logic [rre_pkg::RATIO_W-1:0] rate_target();
    logic [79:0] num;
    logic [79:0] den;
    logic [79:0] quo;
    num = 80'(cfg_now.out_frames);
    num = (num * 80'(in_per)) << RFRAC;
    den = 80'(cfg_now.in_frames);
    den = den * 80'(out_per);
    if (den == 0) return '1;
    quo = num / den;
    if (quo[79:rre_pkg::RATIO_W] != 0) return '1;
    return quo[rre_pkg::RATIO_W-1:0];
  endfunction

  task automatic blend_ratio();
    logic [63:0]                 weight;
    logic [63:0]                 span;
    logic [63:0]                 step;
    logic [rre_pkg::RATIO_W-1:0] target;
    logic [rre_pkg::RATIO_W-1:0] delta;
    if (in_per == 0 || out_per == 0) return;
    weight = 64'(cfg_now.speed);
    if (weight > (64'd1 << SFRAC)) weight = 64'd1 << SFRAC;
    target = rate_target();
    if (target >= ratio_est) begin
      delta = target - ratio_est;
      span = 64'(delta);
      step = (weight * span) >> SFRAC;
      ratio_est = ratio_est + step[rre_pkg::RATIO_W-1:0];
    end else begin
      delta = ratio_est - target;
      span = 64'(delta);
      step = (weight * span) >> SFRAC;
      ratio_est = ratio_est - step[rre_pkg::RATIO_W-1:0];
    end
  endtask

  task automatic estimate_event(input rate_request_t req);
    logic [rre_pkg::TIME_W-1:0] gap;
    ratio_result_t              res;
    case (req.kind)
      rre_pkg::KIND_IN_BLOCK: begin
        gap = req.time_us - in_last;
        if (in_seen && gap != 0) in_per = gap;
        in_last = req.time_us;
        in_seen = 1'b1;
      end
      rre_pkg::KIND_OUT_BLOCK: begin
        gap = req.time_us - out_last;
        if (out_seen && gap != 0) out_per = gap;
        out_last = req.time_us;
        out_seen = 1'b1;
      end
      rre_pkg::KIND_TICK: blend_ratio();
      default: begin
        clear_timing();
        ratio_est = cfg_now.restart_ratio;
      end
    endcase
    res.ratio = ratio_est;
    res.rates_known = (in_per != 0) && (out_per != 0);
    ratio_expected.insert(ratio_expected.size(), res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
    mismatches++;
  endtask

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    rate_request_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) estimate_event('{in_kind, in_time_us});
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (rate_requests.size() != 0) begin
          req = rate_requests.pop_front();
          issued_cnt++;
          in_valid <= 1'b1;
          in_kind <= req.kind;
          in_time_us <= req.time_us;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 45);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares results and stalls the result channel in modes.
  int stall_mode = 0;
  int mode_left = 0;
  int stall_run = 0;

  always @(posedge clk) begin
    ratio_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (ratio_expected.size() == 0) begin
          report_mismatch("unexpected result", out_ratio, '0);
        end else begin
          want = ratio_expected.pop_front();
          if (out_ratio !== want.ratio) report_mismatch("ratio", out_ratio, want.ratio);
          if (out_rates_known !== want.rates_known)
            report_mismatch("rates_known", 32'(out_rates_known), 32'(want.rates_known));
          checked_cnt++;
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(64, 512);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        default: begin
          if (stall_run == 0 && $urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 20);
          out_stall <= (stall_run != 0);
          if (stall_run != 0) stall_run--;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      rre_pkg::REG_IN_FRAMES:  cfg_now.in_frames = value[rre_pkg::FRAMES_W-1:0];
      rre_pkg::REG_OUT_FRAMES: cfg_now.out_frames = value[rre_pkg::FRAMES_W-1:0];
      rre_pkg::REG_SPEED:      cfg_now.speed = value[rre_pkg::SPEED_W-1:0];
      default:                 cfg_now.restart_ratio = value;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] in_f, input logic [15:0] out_f,
                                input logic [16:0] speed, input logic [31:0] init);
    write_register(rre_pkg::REG_IN_FRAMES, {16'd0, in_f});
    write_register(rre_pkg::REG_OUT_FRAMES, {16'd0, out_f});
    write_register(rre_pkg::REG_SPEED, {15'd0, speed});
    write_register(rre_pkg::REG_RESTART_RATIO, init);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (rate_requests.size() != 0 || issued_cnt != checked_cnt);
  endtask

  task automatic push_request(input logic [rre_pkg::KIND_W-1:0] kind,
                              input logic [rre_pkg::TIME_W-1:0] t);
    rate_request_t req;
    req.kind = kind;
    req.time_us = t;
    rate_requests.insert(rate_requests.size(), req);
  endtask

  // Plausible block traffic on an input and an output stream with jitter, plus restarts,
  // repeated timestamps and random noise.
  task automatic queue_rate_traffic(input int count);
    logic [31:0] in_t;
    logic [31:0] out_t;
    logic [31:0] in_p;
    logic [31:0] out_p;
    int          jit;
    int          pick;
    in_t = $urandom();
    out_t = $urandom();
    case ($urandom_range(0, 3))
      0: begin
        in_p = $urandom_range(1, 64);
        out_p = $urandom_range(1, 64);
      end
      1: begin
        in_p = $urandom_range(500, 20000);
        out_p = in_p + $urandom_range(0, 200) - 100;
      end
      2: begin
        in_p = $urandom();
        out_p = $urandom_range(1, 1000);
      end
      default: begin
        in_p = $urandom_range(1, 1000);
        out_p = $urandom();
      end
    endcase
    jit = $urandom_range(0, 8);
    if ($urandom_range(0, 1) == 0) push_request(rre_pkg::KIND_RESTART, $urandom());
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        push_request(rre_pkg::KIND_RESTART, $urandom());
      end else if (pick < 6) begin
        push_request(rre_pkg::KIND_W'($urandom_range(0, 3)), $urandom());
      end else if (pick < 8) begin
        push_request(rre_pkg::KIND_IN_BLOCK, in_t);
      end else if (pick < 10) begin
        push_request(rre_pkg::KIND_OUT_BLOCK, out_t);
      end else if (pick < 45) begin
        in_t = in_t + in_p + $urandom_range(0, 2 * jit) - jit;
        push_request(rre_pkg::KIND_IN_BLOCK, in_t);
      end else if (pick < 80) begin
        out_t = out_t + out_p + $urandom_range(0, 2 * jit) - jit;
        push_request(rre_pkg::KIND_OUT_BLOCK, out_t);
      end else begin
        push_request(rre_pkg::KIND_TICK, $urandom());
      end
    end
  endtask

  initial begin
    cfg_now.in_frames = rre_pkg::FRAMES_RST;
    cfg_now.out_frames = rre_pkg::FRAMES_RST;
    cfg_now.speed = rre_pkg::SPEED_RST;
    cfg_now.restart_ratio = 32'h0100_0000;
    clear_timing();
    ratio_est = 32'h0100_0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    push_request(rre_pkg::KIND_TICK, 32'h0000_0000);
    push_request(rre_pkg::KIND_IN_BLOCK, 32'h0000_0000);
    push_request(rre_pkg::KIND_OUT_BLOCK, 32'hFFFF_FF00);
    push_request(rre_pkg::KIND_TICK, 32'hFFFF_FFFF);
    push_request(rre_pkg::KIND_IN_BLOCK, 32'd1000);
    push_request(rre_pkg::KIND_IN_BLOCK, 32'd1000);
    push_request(rre_pkg::KIND_OUT_BLOCK, 32'h0000_0300);
    push_request(rre_pkg::KIND_TICK, 32'h0000_0000);
    push_request(rre_pkg::KIND_TICK, 32'h1234_5678);
    push_request(rre_pkg::KIND_IN_BLOCK, 32'hFFFF_FFFF);
    push_request(rre_pkg::KIND_OUT_BLOCK, 32'h0000_0301);
    push_request(rre_pkg::KIND_TICK, 32'h0000_0000);
    push_request(rre_pkg::KIND_TICK, 32'hFFFF_FFFF);
    push_request(rre_pkg::KIND_RESTART, 32'hA5A5_A5A5);
    push_request(rre_pkg::KIND_IN_BLOCK, 32'h5A5A_5A5A);
    push_request(rre_pkg::KIND_TICK, 32'h0000_0000);
    push_request(rre_pkg::KIND_RESTART, 32'h0000_0000);
    wait_drained();

    apply_settings(16'h0001, 16'hFFFF, 17'h10000, 32'h0100_0000);
    queue_rate_traffic(125);
    wait_drained();
    apply_settings(16'hFFFF, 16'h0001, 17'd66, 32'hFFFF_FFFF);
    queue_rate_traffic(125);
    wait_drained();
    apply_settings(16'h0000, 16'd480, 17'd655, 32'h0000_0000);
    queue_rate_traffic(125);
    wait_drained();
    apply_settings(16'd441, 16'h0000, 17'h1FFFF, 32'h0000_0001);
    queue_rate_traffic(125);
    wait_drained();
    apply_settings(16'd256, 16'd256, 17'h00000, 32'h0080_0000);
    queue_rate_traffic(125);
    wait_drained();
    apply_settings(16'd480, 16'd441, 17'd655, 32'h0100_0000);
    queue_rate_traffic(125);
    wait_drained();
    for (int p = 0; p < 4; p++) begin
      apply_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                     17'($urandom_range(0, 131071)), $urandom());
      queue_rate_traffic(125);
      wait_drained();
    end

    repeat (64) @(posedge clk);
    if (mismatches == 0 && ratio_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> rate_ratio_estimator.f
design/rre_pkg.sv
design/rre_seq.sv
design/rre_datapath.sv
design/rate_ratio_estimator.sv
tb/sv/testbench.sv
